// ===== rtl/core/wrs_pkg.sv =====
// wrs_pkg: shared constants, codes and channel types of the weighted random select block.
// Depends on nothing. Used by wrs_ctrl, wrs_datapath and weighted_random_select.
package wrs_pkg;

   // table geometry and arithmetic widths
   localparam int TABLE_DEPTH = 64;
   localparam int WEIGHT_BITS = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = IDX_W + 1;
   localparam int SUM_W       = WEIGHT_BITS + IDX_W;
   localparam int TAG_W       = 8;
   localparam int FRAC_BITS   = 16;
   localparam int PROD_W      = FRAC_BITS + SUM_W;
   localparam int ENTRY_W     = SUM_W + TAG_W;

   // opcodes
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_DRAW  = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_NONE = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_ZERO = 2'd3;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] weight;
      logic [7:0]  item_tag;
      logic [15:0] rand_fraction;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] selected_tag;
      logic [5:0] selected_index;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       capture;     // latch the accepted request
      logic       clear;       // empty the table
      logic       load;        // append one entry
      logic       set_status;  // plain result with status code only
      logic [1:0] status;
      logic       start;       // form target, open search window
      logic       read;        // read table at search midpoint
      logic       step;        // narrow the window with the read data
      logic       finish;      // close search, form result
      logic       emit;        // move result into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] opcode;
      logic       weight_zero;
      logic       table_full;
      logic       table_empty;
      logic       search_done;
      logic       out_free;
   } sts_type;

endpackage

// ===== rtl/core/wrs_ram.sv =====
// wrs_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module wrs_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/wrs_ctrl.sv =====
// wrs_ctrl: sequencing state machine of the weighted random select block.
// Depends on wrs_pkg (cmd_type, sts_type, opcode and status codes).
module wrs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  wrs_pkg::sts_type sts,
   output wrs_pkg::cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_DECODE = 5'b00010,
      S_READ   = 5'b00100,
      S_CMP    = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_DONE;
            case (sts.opcode)
               wrs_pkg::OP_CLEAR: begin
                  cmd.clear = 1'b1;
               end
               wrs_pkg::OP_LOAD: begin
                  if (sts.weight_zero) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = wrs_pkg::ST_ZERO;
                  end else if (sts.table_full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = wrs_pkg::ST_FULL;
                  end else begin
                     cmd.load = 1'b1;
                  end
               end
               wrs_pkg::OP_DRAW: begin
                  if (sts.table_empty) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = wrs_pkg::ST_NONE;
                  end else begin
                     cmd.start = 1'b1;
                     state_in  = S_READ;
                  end
               end
               default: begin
                  cmd.set_status = 1'b1;
                  cmd.status     = wrs_pkg::ST_OK;
               end
            endcase
         end
         S_READ: begin
            if (sts.search_done) begin
               cmd.finish = 1'b1;
               state_in   = S_DONE;
            end else begin
               cmd.read = 1'b1;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            cmd.step = 1'b1;
            state_in = S_READ;
         end
         S_DONE: begin
            // hold the result until the output register can take it
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/wrs_datapath.sv =====
// wrs_datapath: table, running total, draw multiply, search window and output register.
// Depends on wrs_pkg and wrs_ram.
module wrs_datapath (
   input  logic             clock,
   input  logic             reset,
   input  wrs_pkg::req_type req_data,
   input  wrs_pkg::cmd_type cmd,
   output wrs_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output wrs_pkg::rsp_type rsp_data
);

   localparam int SUM_W   = wrs_pkg::SUM_W;
   localparam int COUNT_W = wrs_pkg::COUNT_W;
   localparam int IDX_W   = wrs_pkg::IDX_W;
   localparam int TAG_W   = wrs_pkg::TAG_W;

   wrs_pkg::req_type req_ff;
   wrs_pkg::rsp_type res_ff, res_in;
   wrs_pkg::rsp_type rsp_ff;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0]   total_ff, total_in;
   logic [SUM_W-1:0]   target_ff, target_in;
   logic [COUNT_W-1:0] lo_ff, lo_in;
   logic [COUNT_W-1:0] hi_ff, hi_in;
   logic [TAG_W-1:0]   cand_tag_ff, cand_tag_in;

   logic [COUNT_W-1:0]         mid;
   logic [SUM_W-1:0]           new_total;
   logic [wrs_pkg::PROD_W-1:0] product;
   logic [wrs_pkg::ENTRY_W-1:0] rd_entry;
   logic [SUM_W-1:0]           rd_sum;
   logic [TAG_W-1:0]           rd_tag;

   assign new_total = total_ff
                    + {{(SUM_W-wrs_pkg::WEIGHT_BITS){1'b0}},
                       req_ff.weight[wrs_pkg::WEIGHT_BITS-1:0]};
   assign product   = wrs_pkg::PROD_W'(req_ff.rand_fraction) * wrs_pkg::PROD_W'(total_ff);
   assign mid       = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign rd_sum    = rd_entry[wrs_pkg::ENTRY_W-1:TAG_W];
   assign rd_tag    = rd_entry[TAG_W-1:0];

   wrs_ram #(
      .WIDTH (wrs_pkg::ENTRY_W),
      .DEPTH (wrs_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.load),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data ({new_total, req_ff.item_tag}),
      .rd_en   (cmd.read),
      .rd_addr (mid[IDX_W-1:0]),
      .rd_data (rd_entry)
   );

   always_comb begin
      count_in     = count_ff;
      total_in     = total_ff;
      target_in    = target_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      cand_tag_in  = cand_tag_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;

      if (cmd.clear) begin
         count_in = '0;
         total_in = '0;
         res_in   = '{status: wrs_pkg::ST_OK, selected_tag: '0, selected_index: '0};
      end
      if (cmd.load) begin
         count_in = count_ff + COUNT_W'(1);
         total_in = new_total;
         res_in   = '{status: wrs_pkg::ST_OK, selected_tag: '0,
                      selected_index: count_ff[IDX_W-1:0]};
      end
      if (cmd.set_status) begin
         res_in = '{status: cmd.status, selected_tag: '0, selected_index: '0};
      end
      if (cmd.start) begin
         target_in = product[wrs_pkg::PROD_W-1:wrs_pkg::FRAC_BITS];
         lo_in     = '0;
         hi_in     = count_ff;
      end
      if (cmd.step) begin
         // upper bound: keep the tag whenever the window's top moves to mid
         if (rd_sum > target_ff) begin
            hi_in       = mid;
            cand_tag_in = rd_tag;
         end else begin
            lo_in = mid + COUNT_W'(1);
         end
      end
      if (cmd.finish) begin
         if (lo_ff < count_ff) begin
            res_in = '{status: wrs_pkg::ST_OK, selected_tag: cand_tag_ff,
                       selected_index: lo_ff[IDX_W-1:0]};
         end else begin
            res_in = '{status: wrs_pkg::ST_NONE, selected_tag: '0, selected_index: '0};
         end
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.emit) begin
         rsp_ff <= res_ff;
      end
      target_ff   <= target_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      cand_tag_ff <= cand_tag_in;
      res_ff      <= res_in;
   end

   assign sts.opcode      = req_ff.opcode;
   assign sts.weight_zero = (req_ff.weight[wrs_pkg::WEIGHT_BITS-1:0] == '0);
   assign sts.table_full  = (count_ff >= COUNT_W'(wrs_pkg::TABLE_DEPTH));
   assign sts.table_empty = (count_ff == '0) || (total_ff == '0);
   assign sts.search_done = (lo_ff >= hi_ff);
   assign sts.out_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/core/weighted_random_select.sv =====
// Weighted random select: roulette-wheel selection over a 64-entry table of cumulative
// weight sums. Each request takes one transfer and gives exactly one result. Clear, load
// and unused opcodes pass from decode straight to the done state, as does a draw
// on an empty table. A draw multiplies the random fraction by the running total to form
// the search target, then runs an upper-bound binary search in halving steps, each a
// table RAM read followed by a compare. A table of n entries needs at most
// floor(log2(n)) + 1 steps. One request is in work at a time; a finished result waits
// in the output register while the next request is taken. The table needs no
// initialization: after reset it is empty.
// Depends on wrs_pkg, wrs_ctrl, wrs_datapath and wrs_ram.
module weighted_random_select (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  wrs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output wrs_pkg::rsp_type rsp_data
);

   wrs_pkg::cmd_type cmd;
   wrs_pkg::sts_type sts;

   wrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   wrs_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // every request transfer is latched by the datapath
   a_capture_on_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> cmd.capture)
      else $error("request transfer not captured");

   // never overwrite a result that is still stalled at the output
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(rsp_valid && rsp_stall))
      else $error("result emitted over a stalled result");

   // a store happens only into a free slot with a nonzero weight
   a_load_legal: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!sts.table_full && !sts.weight_zero))
      else $error("illegal table store");

   // a search step only runs on a nonempty window
   a_step_window: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !sts.search_done)
      else $error("search step on an empty window");

endmodule
